// File: src/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Types, sizes and codes shared by the first-fit pool allocator.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned POOL_BYTES = 256;
  localparam int unsigned OWNER_BITS = 16;
  localparam int unsigned IDX_W      = $clog2(POOL_BYTES);
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned CNT_W      = 9;

  // request codes
  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_FREE   = 2'd1;
  localparam logic [1:0] REQ_ASSIGN = 2'd2;
  localparam logic [1:0] REQ_COUNT  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_FREE = 2'd2;
  localparam logic [1:0] ST_ILLEGAL  = 2'd3;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [LEN_W-1:0] length;
    logic [7:0]       offset;
    logic [7:0]       byte_value;
  } fpa_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       block_offset;
    logic [CNT_W-1:0] allocated_runs;
    logic [CNT_W-1:0] free_runs;
  } fpa_rsp_t;

endpackage

// File: src/first_fit_pool_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_core
// Byte-granular first-fit allocator over an owner map held in block RAM.
// ----------------------------------------------------------------------------
// Request flow, accept to result valid (size = pool bytes in use):
//   alloc: scan up to size bytes (scan stops at the first fit), then mark the block;
//   count: walk all size bytes; free: length check, then release; assign: owner check.
// One request in flight; the next is taken once the result is parked in the
// output register. Throughput is set by the one-byte-per-cycle owner RAM port.
// Reset: async, active low. Pool size returns to 256, then a clearing pass
// (also run after each pool size write) zeroes the maps; requests stall.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // request channel
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  fpa_pkg::fpa_req_t       in_req_i,
  // result channel
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output fpa_pkg::fpa_rsp_t       out_rsp_o,
  // pool size register
  input  logic                    cfg_we_i,
  input  logic [fpa_pkg::LEN_W-1:0] cfg_wdata_i
);
  import fpa_pkg::*;

  // controller states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1; // first-fit search
  localparam logic [3:0] S_MARK = 4'd2; // stamp owner id over the block
  localparam logic [3:0] S_FCHK = 4'd3; // free: block length read back
  localparam logic [3:0] S_CLR  = 4'd4; // free: release bytes
  localparam logic [3:0] S_ACHK = 4'd5; // assign: owner read back
  localparam logic [3:0] S_CNT  = 4'd6; // run count walk
  localparam logic [3:0] S_DONE = 4'd7; // result waiting for output slot
  localparam logic [3:0] S_INIT = 4'd8; // clearing pass over both maps

  // --------------------------------------------------------------------------
  // Storage. Owner and length RAMs are zeroed by the clearing pass after reset
  // and after a pool size write. Pool data is write-only and never cleared.
  // --------------------------------------------------------------------------
  logic [OWNER_BITS-1:0] own_mem [POOL_BYTES];
  logic [LEN_W-1:0]      len_mem [POOL_BYTES];
  logic [7:0]            data_mem [POOL_BYTES];

  logic [OWNER_BITS-1:0] own_rdata_q;
  logic [LEN_W-1:0]      len_rdata_q;

  // control
  logic [3:0]            state_q;
  fpa_req_t              req_q;
  fpa_rsp_t              res_q;
  logic [LEN_W-1:0]      pool_size_q;
  logic [OWNER_BITS-1:0] next_owner_q;
  logic [LEN_W-1:0]      addr_q;     // next scan read address, reaches size
  logic [IDX_W-1:0]      pidx_q;     // byte whose owner arrives this cycle
  logic                  pend_q;     // a scan read is outstanding
  logic [LEN_W-1:0]      run_q;      // free bytes in current run
  logic [IDX_W-1:0]      start_q;    // run start / granted block start
  logic [IDX_W-1:0]      wr_q;       // mark/clear/init write pointer
  logic [LEN_W-1:0]      rem_q;      // bytes left to mark/clear
  logic [OWNER_BITS-1:0] prev_id_q;
  logic [CNT_W-1:0]      nal_q;
  logic [CNT_W-1:0]      nfr_q;
  logic                  out_valid_q;
  fpa_rsp_t              out_rsp_q;

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]      size;       // pool size capped at the RAM depth
  logic                  accept;
  logic                  in_off_ok;
  logic [IDX_W-1:0]      own_raddr;
  logic [OWNER_BITS-1:0] own_val;
  logic [LEN_W-1:0]      len_val;
  logic                  issue;      // scan read goes out this cycle
  logic                  byte_free;
  logic [LEN_W-1:0]      run_nxt;
  logic                  hit;
  logic [IDX_W-1:0]      hit_start;
  logic                  new_run;
  logic [LEN_W:0]        end_sum;
  logic [LEN_W-1:0]      end_pos;
  logic [OWNER_BITS-1:0] owner_inc;
  logic                  out_free;
  logic                  own_we;
  logic [OWNER_BITS-1:0] own_wdata;
  logic                  len_we;
  logic [IDX_W-1:0]      len_waddr;
  logic [LEN_W-1:0]      len_wdata;

  always_comb begin
    size      = (pool_size_q > LEN_W'(POOL_BYTES)) ? LEN_W'(POOL_BYTES) : pool_size_q;
    accept    = in_valid_i && (state_q == S_IDLE);
    in_off_ok = {1'b0, in_req_i.offset} < size;
    // in idle the owner RAM reads the incoming offset, else the scan address
    own_raddr = (state_q == S_IDLE) ? in_req_i.offset : addr_q[IDX_W-1:0];
    own_val   = own_rdata_q;
    len_val   = len_rdata_q;
    issue     = ((state_q == S_SCAN) || (state_q == S_CNT)) && (addr_q < size);
    byte_free = (own_val == '0);
    run_nxt   = run_q + LEN_W'(1);
    hit       = (state_q == S_SCAN) && pend_q && byte_free && (run_nxt == req_q.length);
    hit_start = (run_q == '0) ? pidx_q : start_q;
    new_run   = (pidx_q == '0) || (own_val != prev_id_q);
    end_sum   = {2'b00, req_q.offset} + {1'b0, len_val};
    end_pos   = (end_sum > {1'b0, size}) ? size : end_sum[LEN_W-1:0];
    owner_inc = next_owner_q + OWNER_BITS'(1);
    out_free  = !out_valid_q || !out_stall_i;
    // one write port per RAM: mark, release or clear
    own_we    = (state_q == S_MARK) || (state_q == S_CLR) || (state_q == S_INIT);
    own_wdata = (state_q == S_MARK) ? next_owner_q : '0;
    len_we    = hit || (state_q == S_INIT) || ((state_q == S_FCHK) && (len_val != '0));
    len_waddr = hit ? hit_start : ((state_q == S_INIT) ? wr_q : req_q.offset);
    len_wdata = hit ? req_q.length : '0;
  end

  // --------------------------------------------------------------------------
  // RAMs: registered read, single write port each
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    own_rdata_q <= own_mem[own_raddr];
    len_rdata_q <= len_mem[in_req_i.offset];
    if (own_we) begin
      own_mem[wr_q] <= own_wdata;
    end
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if ((state_q == S_ACHK) && !byte_free) begin
      data_mem[req_q.offset] <= req_q.byte_value;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      req_q        <= '0;
      res_q        <= '0;
      pool_size_q  <= LEN_W'(POOL_BYTES);
      next_owner_q <= OWNER_BITS'(1);
      addr_q       <= '0;
      pidx_q       <= '0;
      pend_q       <= 1'b0;
      run_q        <= '0;
      start_q      <= '0;
      wr_q         <= '0;
      rem_q        <= '0;
      prev_id_q    <= '0;
      nal_q        <= '0;
      nfr_q        <= '0;
      out_valid_q  <= 1'b0;
      out_rsp_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      // scan bookkeeping shared by alloc and count
      pend_q <= issue;
      if (issue) begin
        addr_q <= addr_q + LEN_W'(1);
        pidx_q <= addr_q[IDX_W-1:0];
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q  <= in_req_i;
            res_q  <= '0;
            addr_q <= '0;
            run_q  <= '0;
            nal_q  <= '0;
            nfr_q  <= '0;
            wr_q   <= in_req_i.offset;
            case (in_req_i.req_type)
              REQ_ALLOC: begin
                if ((in_req_i.length == '0) || (size == '0)) begin
                  res_q.status <= ST_NO_SPACE;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              REQ_FREE: begin
                if (!in_off_ok) begin
                  res_q.status <= ST_BAD_FREE;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_FCHK;
                end
              end
              REQ_ASSIGN: begin
                if (!in_off_ok) begin
                  res_q.status <= ST_ILLEGAL;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_ACHK;
                end
              end
              REQ_COUNT: begin
                state_q <= (size == '0) ? S_DONE : S_CNT;
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (pend_q) begin
            if (byte_free) begin
              run_q <= run_nxt;
              if (run_q == '0) begin
                start_q <= pidx_q;
              end
            end else begin
              run_q <= '0;
            end
          end
          if (hit) begin
            start_q <= hit_start;
            wr_q    <= hit_start;
            rem_q   <= req_q.length;
            state_q <= S_MARK;
          end else if (!issue && !pend_q) begin
            res_q.status <= ST_NO_SPACE;
            state_q      <= S_DONE;
          end
        end

        S_MARK: begin
          wr_q  <= wr_q + IDX_W'(1);
          rem_q <= rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            next_owner_q       <= (owner_inc == '0) ? OWNER_BITS'(1) : owner_inc;
            res_q.status       <= ST_OK;
            res_q.block_offset <= start_q;
            state_q            <= S_DONE;
          end
        end

        S_FCHK: begin
          if (len_val == '0) begin
            res_q.status <= ST_BAD_FREE;
            state_q      <= S_DONE;
          end else begin
            rem_q   <= end_pos - {1'b0, req_q.offset};
            state_q <= S_CLR;
          end
        end

        S_CLR: begin
          wr_q  <= wr_q + IDX_W'(1);
          rem_q <= rem_q - LEN_W'(1);
          if (rem_q == LEN_W'(1)) begin
            res_q.status <= ST_OK;
            state_q      <= S_DONE;
          end
        end

        S_ACHK: begin
          res_q.status <= byte_free ? ST_ILLEGAL : ST_OK;
          state_q      <= S_DONE;
        end

        S_CNT: begin
          if (pend_q) begin
            prev_id_q <= own_val;
            if (new_run) begin
              if (byte_free) begin
                nfr_q <= nfr_q + CNT_W'(1);
              end else begin
                nal_q <= nal_q + CNT_W'(1);
              end
            end
          end else if (!issue) begin
            res_q.allocated_runs <= nal_q;
            res_q.free_runs      <= nfr_q;
            state_q              <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_rsp_q   <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        S_INIT: begin
          wr_q <= wr_q + IDX_W'(1);
          if (wr_q == IDX_W'(POOL_BYTES - 1)) begin
            state_q <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // size write frees the whole pool: restart the clearing pass
      if (cfg_we_i) begin
        pool_size_q  <= cfg_wdata_i;
        next_owner_q <= OWNER_BITS'(1);
        wr_q         <= '0;
        state_q      <= S_INIT;
      end
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_owner_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_owner_q != '0)
    else $error("next owner id is zero");

  a_write_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MARK) || (state_q == S_CLR)) |-> ({1'b0, wr_q} < size))
    else $error("block write beyond pool end");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_runs_fit_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |->
      (({1'b0, res_q.allocated_runs} + {1'b0, res_q.free_runs}) <= {1'b0, size}))
    else $error("run count exceeds pool size");

  a_fail_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && (res_q.status != ST_OK)) |-> (res_q.block_offset == '0))
    else $error("block offset set on a failed request");

endmodule
